>>> rtl/fpc_pkg.sv
package fpc_pkg;

    // Point coordinates and the plane offset are Q15.6, the plane normal is Q1.12.
    localparam int COORD_W = 22;
    localparam int COEF_W  = 14;
    localparam int OFFS_W  = 22;

    // Bit positions of the fields inside one 64-bit plane register.
    localparam int CFG_W    = 64;
    localparam int COEF_A_LO = 50;
    localparam int COEF_B_LO = 36;
    localparam int COEF_C_LO = 22;
    localparam int OFFS_LO   = 0;

    // The offset is moved up by 12 bits so that it lines up with the Q.18 products.
    localparam int OFFS_SHIFT = 12;

    // Product of one coefficient and one coordinate, and the full distance sum.
    localparam int PROD_W = COEF_W + COORD_W;
    localparam int DIST_W = PROD_W + 2;

    // Register index port, wide enough for the largest plane count.
    localparam int CFG_IDX_W = 3;

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 8;

    // Queue between the plane test and the group accumulator.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [DIST_W-1:0]  dist_t;

    // Verdict on one point, as it travels from the plane test to the accumulator.
    typedef struct packed {
        logic hit;
        logic last;
    } cull_item_t;

endpackage

>>> rtl/frustum_point_cull.sv
// Frustum visibility test for groups of sample points.
// Six plane registers (index 0 to NUM_PLANES-1 on the configuration port) each
// hold a, b, c in Q1.12 and d in Q15.6. Writes to a higher index are dropped.
// Points arrive on the s_axis channel, one request per point; s_axis_tlast
// marks the final point of a group. A point is inside when a*x+b*y+c*z+d is
// strictly positive for every plane. For each group one request leaves on
// m_axis, bit 0 set when any point of the group was inside.
// Throughput is one point per cycle while nothing stalls: the plane test is a
// three-stage pipeline of per-plane multipliers, partial sums and a sign check,
// all planes in parallel. A group result is registered on m_axis once its last
// point has passed the pipeline, the queue and the accumulator.
// A four-entry queue sits between the plane test and the group accumulator, so
// the input keeps flowing while a result waits; when the receiver stalls, only
// points that close a group hold the accumulator, and s_axis_tready falls once
// the queue is full and the last pipeline stage holds a point.
// Reset clears the plane registers (every point then tests outside), the
// running group flag and all pending work.
module frustum_point_cull #(
    parameter int NUM_PLANES = 6
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [fpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fpc_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0: point_x [21:0], point_y [43:22], point_z [65:44], zero fill.
    input  logic [fpc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // last_point.
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0: group_visible [0], zero fill.
    output logic [fpc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    fpc_pkg::coord_t     point_x;
    fpc_pkg::coord_t     point_y;
    fpc_pkg::coord_t     point_z;

    logic                test_valid;
    logic                test_ready;
    fpc_pkg::cull_item_t test_item;
    logic                queue_valid;
    logic                queue_ready;
    fpc_pkg::cull_item_t queue_item;
    logic                group_visible;

    assign point_x = s_axis_tdata[0 +: fpc_pkg::COORD_W];
    assign point_y = s_axis_tdata[fpc_pkg::COORD_W +: fpc_pkg::COORD_W];
    assign point_z = s_axis_tdata[2*fpc_pkg::COORD_W +: fpc_pkg::COORD_W];

    // Front: plane registers and the per-point inside test.
    fpc_plane_test #(
        .NUM_PLANES (NUM_PLANES)
    ) u_plane_test (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_x      (point_x),
        .in_y      (point_y),
        .in_z      (point_z),
        .in_last   (s_axis_tlast),
        .out_valid (test_valid),
        .out_item  (test_item),
        .out_ready (test_ready)
    );

    // Decouples the pipeline from a stalled result.
    fpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (test_valid),
        .in_ready  (test_ready),
        .in_item   (test_item),
        .out_valid (queue_valid),
        .out_item  (queue_item),
        .out_ready (queue_ready)
    );

    // Back: running group flag and the registered result.
    fpc_group_acc u_group_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (queue_valid),
        .in_ready    (queue_ready),
        .in_item     (queue_item),
        .out_valid   (m_axis_tvalid),
        .out_visible (group_visible),
        .out_ready   (m_axis_tready)
    );

    assign m_axis_tdata = {{(fpc_pkg::OUT_TDATA_W-1){1'b0}}, group_visible};

endmodule

>>> rtl/fpc_plane_test.sv
module fpc_plane_test #(
    parameter int NUM_PLANES = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fpc_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  fpc_pkg::coord_t                in_x,
    input  fpc_pkg::coord_t                in_y,
    input  fpc_pkg::coord_t                in_z,
    input  logic                           in_last,
    output logic                           out_valid,
    output fpc_pkg::cull_item_t            out_item,
    input  logic                           out_ready
);

    logic [fpc_pkg::CFG_W-1:0] plane_reg [NUM_PLANES];

    logic                s1_valid_reg;
    logic                s1_last_reg;
    fpc_pkg::prod_t      prod_a_reg [NUM_PLANES];
    fpc_pkg::prod_t      prod_b_reg [NUM_PLANES];
    fpc_pkg::prod_t      prod_c_reg [NUM_PLANES];
    fpc_pkg::dist_t      offs_reg   [NUM_PLANES];

    logic                s2_valid_reg;
    logic                s2_last_reg;
    fpc_pkg::dist_t      sum_ab_reg [NUM_PLANES];
    fpc_pkg::dist_t      sum_cd_reg [NUM_PLANES];

    logic                s3_valid_reg;
    fpc_pkg::cull_item_t s3_item_reg;

    logic                advance;
    logic                hit_next;
    fpc_pkg::dist_t      plane_dist [NUM_PLANES];

    // The three stages move together; a bubble at the end lets them move regardless.
    assign advance   = !s3_valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = s3_valid_reg;
    assign out_item  = s3_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                plane_reg[p] <= '0;
            end
        end
        else if (cfg_we)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                if (cfg_index == fpc_pkg::CFG_IDX_W'(p))
                begin
                    plane_reg[p] <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 1: one product per coefficient and plane; stage 2: two partial sums.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_last_reg <= in_last;
            s2_last_reg <= s1_last_reg;
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                prod_a_reg[p] <= fpc_pkg::prod_t'($signed(
                                     plane_reg[p][fpc_pkg::COEF_A_LO +: fpc_pkg::COEF_W]))
                                 * fpc_pkg::prod_t'(in_x);
                prod_b_reg[p] <= fpc_pkg::prod_t'($signed(
                                     plane_reg[p][fpc_pkg::COEF_B_LO +: fpc_pkg::COEF_W]))
                                 * fpc_pkg::prod_t'(in_y);
                prod_c_reg[p] <= fpc_pkg::prod_t'($signed(
                                     plane_reg[p][fpc_pkg::COEF_C_LO +: fpc_pkg::COEF_W]))
                                 * fpc_pkg::prod_t'(in_z);
                offs_reg[p]   <= fpc_pkg::dist_t'($signed(
                                     {plane_reg[p][fpc_pkg::OFFS_LO +: fpc_pkg::OFFS_W],
                                      {fpc_pkg::OFFS_SHIFT{1'b0}}}));
                sum_ab_reg[p] <= fpc_pkg::dist_t'(prod_a_reg[p])
                                 + fpc_pkg::dist_t'(prod_b_reg[p]);
                sum_cd_reg[p] <= fpc_pkg::dist_t'(prod_c_reg[p]) + offs_reg[p];
            end
        end
    end

    // Stage 3: the point is inside only when every distance is strictly positive.
    always_comb
    begin
        hit_next = 1'b1;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            plane_dist[p] = sum_ab_reg[p] + sum_cd_reg[p];
            if (plane_dist[p] <= fpc_pkg::dist_t'(0))
            begin
                hit_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_item_reg.hit  <= hit_next;
            s3_item_reg.last <= s2_last_reg;
        end
    end

endmodule

>>> rtl/fpc_queue.sv
module fpc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fpc_pkg::cull_item_t in_item,
    output logic                out_valid,
    output fpc_pkg::cull_item_t out_item,
    input  logic                out_ready
);

    fpc_pkg::cull_item_t             mem [fpc_pkg::QUEUE_DEPTH];
    logic [fpc_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [fpc_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [fpc_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic                            push;
    logic                            pop;

    assign in_ready  = count_reg != fpc_pkg::QUEUE_CNT_W'(fpc_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + fpc_pkg::QUEUE_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + fpc_pkg::QUEUE_PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + fpc_pkg::QUEUE_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - fpc_pkg::QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/fpc_group_acc.sv
module fpc_group_acc (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fpc_pkg::cull_item_t in_item,
    output logic                out_valid,
    output logic                out_visible,
    input  logic                out_ready
);

    logic any_inside_reg;
    logic any_inside_next;
    logic out_valid_reg;
    logic out_visible_reg;
    logic pop;

    // A point that closes a group waits until the result register is free.
    assign in_ready        = !in_item.last || !out_valid_reg || out_ready;
    assign pop             = in_valid && in_ready;
    assign any_inside_next = any_inside_reg || in_item.hit;
    assign out_valid       = out_valid_reg;
    assign out_visible     = out_visible_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_inside_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop && in_item.last)
            begin
                any_inside_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else
            begin
                if (pop)
                begin
                    any_inside_reg <= any_inside_next;
                end
                if (out_ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && in_item.last)
        begin
            out_visible_reg <= any_inside_next;
        end
    end

endmodule

>>> bench/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // The block under test is built with its default of six planes.
    localparam int NUM_PLANES = 6;

    // The highest register index that the index port can carry. Indexes from
    // NUM_PLANES up to this one name no plane, so the block must drop them.
    localparam int LAST_CFG_INDEX = (1 << fpc_pkg::CFG_IDX_W) - 1;

    // Limits of a Q15.6 coordinate or offset, and of a Q1.12 coefficient.
    localparam int COORD_MAX = (1 << (fpc_pkg::COORD_W - 1)) - 1;
    localparam int COORD_MIN = -(1 << (fpc_pkg::COORD_W - 1));
    localparam int COEF_MAX  = (1 << (fpc_pkg::COEF_W - 1)) - 1;
    localparam int COEF_MIN  = -(1 << (fpc_pkg::COEF_W - 1));

    // 1.0 in Q1.12, used for the plane normals of the box-shaped frusta.
    localparam int COEF_ONE = 1 << (fpc_pkg::COEF_W - 2);

    // The offset d is Q15.6 while the products are Q.18, so d is scaled up.
    localparam longint OFFS_SCALE = 64'sd1 << fpc_pkg::OFFS_SHIFT;

    // Percentages of cycles in which a side idles or stalls.
    localparam int BUSY_PCT  = 71;
    localparam int LIGHT_PCT = 11;

    // Points that close no group may still be in the block's pipeline when
    // the last expected result has come, so every drain lets the clock run
    // on by this pad.
    localparam int DRAIN_PAD = 16;

    // Length of the long receiver hold-off, in cycles.
    localparam int LONG_HOLD = 300;

    // Random part: eight phases of about 225 points each.
    localparam int NUM_PHASES      = 8;
    localparam int POINTS_PER_PHASE = 225;

    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef logic signed [fpc_pkg::COEF_W-1:0] coef_t;
    typedef logic signed [fpc_pkg::OFFS_W-1:0] offs_t;

    // One sample point as it is offered on the input stream.
    typedef struct packed {
        logic            last;
        fpc_pkg::coord_t z;
        fpc_pkg::coord_t y;
        fpc_pkg::coord_t x;
    } point_t;

    typedef enum {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SINK,
        IDLE_BOTH
    } idle_mode_t;

    // The kinds of plane sets that the random phases run under.
    typedef enum {
        PLANES_BOX,
        PLANES_ALL_ONES,
        PLANES_EXTREME,
        PLANES_RANDOM
    } plane_set_t;

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [fpc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [fpc_pkg::CFG_W-1:0]       cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [fpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [fpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // Our own copy of the plane registers and of the running group flag.
    logic [fpc_pkg::CFG_W-1:0] plane_model [NUM_PLANES];
    logic                      group_seen_inside = 1'b0;

    // Points waiting to be offered, and the visible bits still owed by the block.
    point_t pending_points [$];
    logic   expected_visible_q [$];

    // The point currently offered on the input stream.
    point_t src_item;
    logic   want_visible;

    // Idling controls, changed only at falling edges by the stimulus process.
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    bit sink_hold      = 1'b0;

    // Half-width of the region the random points mostly fall into.
    int box_span = 1000;

    int          error_count = 0;
    int          groups_checked = 0;
    int unsigned cycle_count = 0;

    frustum_point_cull #(
        .NUM_PLANES(NUM_PLANES)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // A point is inside only if its distance to every plane is strictly
    // positive. The sum is formed exactly in 64 bits, so a distance of
    // exactly zero counts as outside.
    function automatic logic point_in_frustum(point_t p);
        fpc_pkg::coord_t    px;
        fpc_pkg::coord_t    py;
        fpc_pkg::coord_t    pz;
        coef_t              ca;
        coef_t              cb;
        coef_t              cc;
        offs_t              off;
        logic signed [63:0] signed_dist;
        px = p.x;
        py = p.y;
        pz = p.z;
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            ca   = plane_model[i][fpc_pkg::COEF_A_LO +: fpc_pkg::COEF_W];
            cb   = plane_model[i][fpc_pkg::COEF_B_LO +: fpc_pkg::COEF_W];
            cc   = plane_model[i][fpc_pkg::COEF_C_LO +: fpc_pkg::COEF_W];
            off  = plane_model[i][fpc_pkg::OFFS_LO +: fpc_pkg::OFFS_W];
            signed_dist = longint'(ca) * longint'(px) + longint'(cb) * longint'(py)
                          + longint'(cc) * longint'(pz) + longint'(off) * OFFS_SCALE;
            if (signed_dist <= 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Folds one accepted point into the group flag. The last point of a
    // group counts itself, owes one visible bit and clears the flag.
    function automatic void account_point(point_t p);
        if (point_in_frustum(p))
            group_seen_inside = 1'b1;
        if (p.last)
        begin
            expected_visible_q.push_back(group_seen_inside);
            group_seen_inside = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic logic [fpc_pkg::CFG_W-1:0] plane_word(int a, int b, int c, int d);
        return {coef_t'(a), coef_t'(b), coef_t'(c), offs_t'(d)};
    endfunction

    // Mostly the two ends of a range, zero, or anything in between.
    function automatic int pick_extreme(int lo, int hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            2:       return 0;
            default: return int'($urandom_range(0, hi - lo)) + lo;
        endcase
    endfunction

    // Most coordinates land around the current box so that the plane tests
    // go both ways; the rest cover the whole field and its extremes.
    function automatic fpc_pkg::coord_t rand_coord();
        int pick;
        int span;
        pick = $urandom_range(0, 99);
        span = box_span + box_span / 4;
        if (pick < 70)
            return fpc_pkg::coord_t'(int'($urandom_range(0, 2 * span)) - span);
        if (pick < 90)
            return fpc_pkg::coord_t'($urandom);
        case ($urandom_range(0, 6))
            0:       return fpc_pkg::coord_t'(COORD_MAX);
            1:       return fpc_pkg::coord_t'(COORD_MIN);
            2:       return fpc_pkg::coord_t'(0);
            3:       return fpc_pkg::coord_t'(-1);
            4:       return fpc_pkg::coord_t'(1);
            5:       return fpc_pkg::coord_t'(box_span);
            default: return fpc_pkg::coord_t'(-box_span);
        endcase
    endfunction

    function automatic void push_point(int x, int y, int z, logic last);
        point_t p;
        p.x    = fpc_pkg::coord_t'(x);
        p.y    = fpc_pkg::coord_t'(y);
        p.z    = fpc_pkg::coord_t'(z);
        p.last = last;
        pending_points.push_back(p);
    endfunction

    // Register writes happen only while the block is idle, so the copy of
    // the planes can follow the write at once.
    task automatic write_plane_reg(input int idx, input logic [fpc_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= fpc_pkg::CFG_IDX_W'(idx);
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx < NUM_PLANES)
            plane_model[idx] = value;
        @(negedge clk);
    endtask

    // Waits until every point has been taken and every group answered, then
    // lets the pipeline run dry.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_points.size() != 0 || s_axis_tvalid || expected_visible_q.size() != 0);
        repeat (DRAIN_PAD) @(negedge clk);
    endtask

    task automatic set_idling(input idle_mode_t mode);
        @(negedge clk);
        case (mode)
            IDLE_NONE:
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            IDLE_SRC:
            begin
                src_idle_pct   = BUSY_PCT;
                sink_stall_pct = 0;
            end
            IDLE_SINK:
            begin
                src_idle_pct   = 0;
                sink_stall_pct = BUSY_PCT;
            end
            default:
            begin
                src_idle_pct   = LIGHT_PCT;
                sink_stall_pct = LIGHT_PCT;
            end
        endcase
    endtask

    task automatic load_planes(input plane_set_t kind);
        int n [3];
        int sgn;
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            case (kind)
                PLANES_BOX:
                begin
                    // An axis-aligned box, slightly tilted: even planes keep
                    // coord > -d, odd planes keep coord < d.
                    if (i == 0)
                        box_span = $urandom_range(64, 1500000);
                    sgn = (i % 2 == 0) ? 1 : -1;
                    for (int k = 0; k < 3; k++)
                        n[k] = int'($urandom_range(0, 600)) - 300;
                    n[i / 2] = sgn * (COEF_ONE - int'($urandom_range(0, 400)));
                    write_plane_reg(i, plane_word(n[0], n[1], n[2],
                                                  box_span + int'($urandom_range(0, 64))));
                end
                PLANES_ALL_ONES:
                begin
                    // a = b = c = d = -1: inside only where x + y + z < -4096.
                    if (i == 0)
                        box_span = $urandom_range(1, COORD_MAX);
                    write_plane_reg(i, '1);
                end
                PLANES_EXTREME:
                begin
                    // About half the planes pass everything, the others draw coefficients
                    // and offset from pick_extreme: mostly range ends or zero.
                    if (i == 0)
                        box_span = $urandom_range(1, COORD_MAX);
                    if ($urandom_range(0, 1) == 0)
                        write_plane_reg(i, plane_word(0, 0, 0, COORD_MAX));
                    else
                        write_plane_reg(i, plane_word(pick_extreme(COEF_MIN, COEF_MAX),
                                                      pick_extreme(COEF_MIN, COEF_MAX),
                                                      pick_extreme(COEF_MIN, COEF_MAX),
                                                      pick_extreme(COORD_MIN, COORD_MAX)));
                end
                default:
                begin
                    if (i == 0)
                        box_span = $urandom_range(1, COORD_MAX);
                    write_plane_reg(i, {$urandom, $urandom});
                end
            endcase
        end
        // Now and then a write to an index with no plane behind it.
        if ($urandom_range(0, 1) == 0)
            write_plane_reg($urandom_range(NUM_PLANES, LAST_CFG_INDEX), {$urandom, $urandom});
    endtask

    // Groups are mostly short; single-point groups and long runs are mixed in.
    task automatic queue_random_groups(input int n_points);
        int left;
        int len;
        int pick;
        left = n_points;
        while (left > 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                len = 1;
            else if (pick < 85)
                len = $urandom_range(2, 8);
            else
                len = $urandom_range(9, 40);
            for (int k = 0; k < len; k++)
                push_point(rand_coord(), rand_coord(), rand_coord(), k == len - 1);
            left -= len;
        end
    endtask

    // Sender. A point is taken into the model at the edge where its request
    // is accepted. A new point is only put up once the last one is gone, and
    // each idle roll decides whether the next cycle carries a request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                account_point(src_item);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_points.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    src_item = pending_points.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(fpc_pkg::IN_TDATA_W - 3 * fpc_pkg::COORD_W){1'b0}},
                                      src_item.z, src_item.y, src_item.x};
                    s_axis_tlast  <= src_item.last;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Every accepted result is checked against the oldest owed
    // visible bit; the zero fill above bit 0 is checked as well.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_visible_q.size() == 0)
                begin
                    report_mismatch($sformatf("result 0x%0h arrived with no group pending",
                                              m_axis_tdata));
                end
                else
                begin
                    want_visible = expected_visible_q.pop_front();
                    if (m_axis_tdata !== fpc_pkg::OUT_TDATA_W'(want_visible))
                        report_mismatch($sformatf("group %0d: tdata 0x%0h, visible should be %0b",
                                                  groups_checked, m_axis_tdata, want_visible));
                    groups_checked++;
                end
            end
            m_axis_tready <= !sink_hold && ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < NUM_PLANES; i++)
            plane_model[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. With the planes as reset leaves them every distance
        // is zero, so no group can be visible.
        push_point(0, 0, 0, 1'b1);
        push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        wait_drained();

        // Planes 1 to 5 pass every point; plane 0 keeps only x > 0, which
        // puts a point with x = 0 exactly on the plane.
        for (int i = 1; i < NUM_PLANES; i++)
            write_plane_reg(i, plane_word(0, 0, 0, 1));
        write_plane_reg(0, plane_word(COEF_ONE, 0, 0, 0));
        push_point(0, 5, 5, 1'b1);
        push_point(1, COORD_MIN, COORD_MAX, 1'b1);
        push_point(-1, 0, 0, 1'b0);
        push_point(0, 0, 0, 1'b0);
        push_point(COORD_MAX, 0, 0, 1'b1);
        push_point(COORD_MIN, 0, 0, 1'b1);
        // The flag must carry over an outside last point, then clear.
        push_point(1, 0, 0, 1'b0);
        push_point(-5, 0, 0, 1'b1);
        push_point(0, 0, 0, 1'b1);
        wait_drained();

        // Writes beyond the last plane must leave the planes alone.
        for (int i = NUM_PLANES; i <= LAST_CFG_INDEX; i++)
            write_plane_reg(i, '0);
        push_point(1, 0, 0, 1'b1);
        wait_drained();

        // Coefficients at the ends of their ranges against extreme points.
        write_plane_reg(0, plane_word(COEF_MAX, COEF_MIN, COEF_MAX, COORD_MIN));
        push_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
        push_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
        push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        push_point(0, 0, 0, 1'b1);
        wait_drained();
        for (int i = 0; i < NUM_PLANES; i++)
            write_plane_reg(i, '1);
        push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);

        // Random part. Even phases run box frusta, odd phases the other plane
        // sets, and the idling pattern rotates every phase. The phases with
        // no idling on either side also hold the receiver off for a long stretch, so
        // the result queue fills and the input stalls.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            if (ph % 2 == 0)
                load_planes(PLANES_BOX);
            else if (ph == 1)
                load_planes(PLANES_ALL_ONES);
            else if (ph == 5)
                load_planes(PLANES_RANDOM);
            else
                load_planes(PLANES_EXTREME);
            set_idling(idle_mode_t'(ph % 4));
            if (ph % 4 == 0)
            begin
                fork
                    begin
                        sink_hold = 1'b1;
                        repeat (LONG_HOLD) @(negedge clk);
                        sink_hold = 1'b0;
                    end
                join_none
            end
            queue_random_groups(POINTS_PER_PHASE);
        end

        wait_drained();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
rtl/fpc_pkg.sv
rtl/fpc_plane_test.sv
rtl/fpc_queue.sv
rtl/fpc_group_acc.sv
rtl/frustum_point_cull.sv
bench/tb_top.sv
